/* rtl/core/lc3_pkg.sv */
// Shared types and constants for the LC-3 instruction executor.
// Holds the transaction structs, opcode and kind codes and the sequencer state type.
// Depends on nothing.
`timescale 1ns / 1ps

package lc3_pkg;

  localparam int unsigned MEM_WORDS_DEF = 65536;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] CC_NEG  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_HALT = 4'hF;

  localparam logic [15:0] REG_INIT   = 16'h7777;
  localparam logic [15:0] PC_RESET   = 16'h3000;
  localparam logic [15:0] START_INIT = 16'h3000;
  localparam logic [2:0]  LINK_REG   = 3'd7;

  // Index of the start address register, taken from paddr[2]
  localparam logic CFG_START = 1'b0;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_AND,
    ALU_NOT
  } alu_fn_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_Q,
    S_LD_WR,
    S_RREG,
    S_IF_Q,
    S_IF_RD,
    S_IF_WT,
    S_OFS,
    S_RDB,
    S_ADDR,
    S_M1_Q,
    S_M1_RD,
    S_M1_WT,
    S_M2_Q,
    S_M2_RD,
    S_M2_WT,
    S_ST_Q,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [2:0]  reg_select;
  } item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic [1:0]  cond_code;
    logic        reg_written;
    logic [2:0]  reg_number;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [15:0] mem_address;
    logic [15:0] mem_value;
  } result_t;

  function automatic logic [1:0] cc_of(input logic [15:0] v);
    logic [1:0] cc;
    if (v == 16'd0) begin
      cc = CC_ZERO;
    end else if (v[15]) begin
      cc = CC_NEG;
    end else begin
      cc = CC_POS;
    end
    return cc;
  endfunction

endpackage

/* rtl/core/lc3_instruction_executor.sv */
// Top level of the LC-3 instruction executor: sequencer, shared ALU and state.
// Depends on lc3_pkg and lc3_ram.
`timescale 1ns / 1ps

// After reset the block sweeps the word memory to zero, one word per cycle; busy stays high
// meanwhile and configuration writes are still taken. A transaction is taken when start is
// high and busy is low; its result shows on result_o for exactly one cycle, marked by done_o,
// and the receiver cannot stall it. The result is registered and comes in the cycle after
// the last busy cycle: a start transaction and a step while halted finish at once (result on
// the next cycle), a register read passes through S_RREG and a memory load through S_LD_Q and
// S_LD_WR. A step walks a sequencer around one 16-bit ALU and the word memory (one write port,
// one read port): fetch, offset add, register reads and address add, then for LD, LDR, LDI and
// STI a first memory read, for LDI a second one, for ST, STR and STI a wait on the folded store
// address, and last the execute state. Each memory access first registers the quotient that
// folds the 16-bit address into the memory depth, then does the synchronous read or the write.
module lc3_instruction_executor #(
  parameter int unsigned MEM_WORDS = lc3_pkg::MEM_WORDS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lc3_pkg::item_t   item_i,
  output logic             done_o,
  output lc3_pkg::result_t result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned AW       = $clog2(MEM_WORDS);
  localparam int unsigned RECIP_W  = 34 - AW;
  localparam int unsigned Q_W      = RECIP_W - 16;
  localparam int unsigned PROD_W   = RECIP_W + 16;
  localparam int unsigned QM_W     = Q_W + 17;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << 32) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS));
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

  lc3_pkg::state_e  state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [15:0]      pc_q, pc_d;
  logic [1:0]       cc_q, cc_d;
  logic             halt_q, halt_d;
  logic [7:0]       rf_valid_q, rf_valid_d;
  logic             done_q, done_d;
  logic [15:0]      start_q;
  lc3_pkg::result_t result_q, result_d;

  logic [15:0]      ir_q, ir_d;
  logic [15:0]      pc1_q, pc1_d;
  logic [15:0]      tgt_q, tgt_d;
  logic [15:0]      a_q, a_d;
  logic [15:0]      b_q, b_d;
  logic [15:0]      m_q, m_d;
  logic [15:0]      maddr_q, maddr_d;
  logic [2:0]       rsel_q, rsel_d;
  logic [Q_W-1:0]   quo_q;
  logic             rf_vld_q;

  logic             accept;
  logic [3:0]       opc;
  logic [2:0]       dr, sr1, sr2;
  logic [15:0]      off9, off11, off6, imm5;
  logic             br_taken;

  logic [PROD_W-1:0] prod;
  logic [QM_W-1:0]   qm;
  logic [16:0]       phys_full;
  logic [AW-1:0]     phys;

  lc3_pkg::alu_fn_e alu_fn;
  logic [15:0]      alu_x, alu_y, alu_r;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr;
  logic [15:0]      mem_wdata, mem_rdata;
  logic             rf_we;
  logic [2:0]       rf_waddr, rf_raddr;
  logic [15:0]      rf_wdata, rf_rdata, rf_eff;
  logic             cfg_we;

  assign busy   = (state_q != lc3_pkg::S_IDLE);
  assign accept = start & ~busy;

  assign opc   = ir_q[15:12];
  assign dr    = ir_q[11:9];
  assign sr1   = ir_q[8:6];
  assign sr2   = ir_q[2:0];
  assign off9  = {{7{ir_q[8]}}, ir_q[8:0]};
  assign off11 = {{5{ir_q[10]}}, ir_q[10:0]};
  assign off6  = {{10{ir_q[5]}}, ir_q[5:0]};
  assign imm5  = {{11{ir_q[4]}}, ir_q[4:0]};

  assign br_taken = ((cc_q == lc3_pkg::CC_NEG)  && ir_q[11]) ||
                    ((cc_q == lc3_pkg::CC_ZERO) && ir_q[10]) ||
                    ((cc_q == lc3_pkg::CC_POS)  && ir_q[9]);

  // Fold the 16-bit address into the memory depth: quotient by reciprocal, then remainder
  assign prod      = PROD_W'(maddr_q) * PROD_W'(RECIP);
  assign qm        = QM_W'(quo_q) * QM_W'(MEM_WORDS);
  assign phys_full = {1'b0, maddr_q} - qm[16:0];
  assign phys      = phys_full[AW-1:0];

  always_comb begin
    case (alu_fn)
      lc3_pkg::ALU_ADD: alu_r = alu_x + alu_y;
      lc3_pkg::ALU_AND: alu_r = alu_x & alu_y;
      lc3_pkg::ALU_NOT: alu_r = ~alu_x;
      default:          alu_r = alu_x + alu_y;
    endcase
  end

  assign rf_eff = rf_vld_q ? rf_rdata : lc3_pkg::REG_INIT;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == lc3_pkg::CFG_START);
  assign prdata = (paddr[2] == lc3_pkg::CFG_START) ? {16'd0, start_q} : 32'd0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lc3_pkg::S_CLEAR: begin
        if (clr_q == CLR_LAST) begin
          state_d = lc3_pkg::S_IDLE;
        end
      end
      lc3_pkg::S_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            lc3_pkg::KIND_LOAD: state_d = lc3_pkg::S_LD_Q;
            lc3_pkg::KIND_READ: state_d = lc3_pkg::S_RREG;
            lc3_pkg::KIND_STEP: begin
              if (!halt_q) begin
                state_d = lc3_pkg::S_IF_Q;
              end
            end
            default: state_d = lc3_pkg::S_IDLE;
          endcase
        end
      end
      lc3_pkg::S_LD_Q:  state_d = lc3_pkg::S_LD_WR;
      lc3_pkg::S_LD_WR: state_d = lc3_pkg::S_IDLE;
      lc3_pkg::S_RREG:  state_d = lc3_pkg::S_IDLE;
      lc3_pkg::S_IF_Q:  state_d = lc3_pkg::S_IF_RD;
      lc3_pkg::S_IF_RD: state_d = lc3_pkg::S_IF_WT;
      lc3_pkg::S_IF_WT: state_d = lc3_pkg::S_OFS;
      lc3_pkg::S_OFS:   state_d = lc3_pkg::S_RDB;
      lc3_pkg::S_RDB:   state_d = lc3_pkg::S_ADDR;
      lc3_pkg::S_ADDR: begin
        if (opc inside {lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_LDR, lc3_pkg::OP_STI}) begin
          state_d = lc3_pkg::S_M1_Q;
        end else if (opc inside {lc3_pkg::OP_ST, lc3_pkg::OP_STR}) begin
          state_d = lc3_pkg::S_ST_Q;
        end else begin
          state_d = lc3_pkg::S_EXEC;
        end
      end
      lc3_pkg::S_M1_Q:  state_d = lc3_pkg::S_M1_RD;
      lc3_pkg::S_M1_RD: state_d = lc3_pkg::S_M1_WT;
      lc3_pkg::S_M1_WT: begin
        if (opc == lc3_pkg::OP_LDI) begin
          state_d = lc3_pkg::S_M2_Q;
        end else if (opc == lc3_pkg::OP_STI) begin
          state_d = lc3_pkg::S_ST_Q;
        end else begin
          state_d = lc3_pkg::S_EXEC;
        end
      end
      lc3_pkg::S_M2_Q:  state_d = lc3_pkg::S_M2_RD;
      lc3_pkg::S_M2_RD: state_d = lc3_pkg::S_M2_WT;
      lc3_pkg::S_M2_WT: state_d = lc3_pkg::S_EXEC;
      lc3_pkg::S_ST_Q:  state_d = lc3_pkg::S_EXEC;
      lc3_pkg::S_EXEC:  state_d = lc3_pkg::S_IDLE;
      default:          state_d = lc3_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic        rw;
    logic [2:0]  rn;
    logic [15:0] rv;
    logic        mw;

    rw = 1'b0;
    rn = 3'd0;
    rv = 16'd0;
    mw = 1'b0;

    clr_d      = clr_q;
    pc_d       = pc_q;
    cc_d       = cc_q;
    halt_d     = halt_q;
    rf_valid_d = rf_valid_q;
    done_d     = 1'b0;
    result_d   = '0;
    ir_d       = ir_q;
    pc1_d      = pc1_q;
    tgt_d      = tgt_q;
    a_d        = a_q;
    b_d        = b_q;
    m_d        = m_q;
    maddr_d    = maddr_q;
    rsel_d     = rsel_q;

    alu_fn    = lc3_pkg::ALU_ADD;
    alu_x     = pc_q;
    alu_y     = 16'd1;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = phys;
    mem_wdata = b_q;
    rf_we     = 1'b0;
    rf_waddr  = 3'd0;
    rf_wdata  = 16'd0;
    rf_raddr  = sr1;

    case (state_q)
      lc3_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 16'd0;
        clr_d     = clr_q + AW'(1);
      end
      lc3_pkg::S_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            lc3_pkg::KIND_LOAD: begin
              maddr_d = item_i.load_address;
              b_d     = item_i.load_data;
            end
            lc3_pkg::KIND_START: begin
              pc_d       = start_q;
              cc_d       = lc3_pkg::CC_ZERO;
              halt_d     = 1'b0;
              rf_valid_d = '0;
              done_d     = 1'b1;
            end
            lc3_pkg::KIND_READ: begin
              rf_raddr = item_i.reg_select;
              rsel_d   = item_i.reg_select;
            end
            lc3_pkg::KIND_STEP: begin
              maddr_d = pc_q;
              done_d  = halt_q;
            end
            default: done_d = 1'b0;
          endcase
        end
      end
      lc3_pkg::S_LD_WR: begin
        mem_we = 1'b1;
        done_d = 1'b1;
      end
      lc3_pkg::S_RREG: begin
        rn     = rsel_q;
        rv     = rf_eff;
        done_d = 1'b1;
      end
      lc3_pkg::S_IF_RD: mem_re = 1'b1;
      lc3_pkg::S_IF_WT: begin
        ir_d  = mem_rdata;
        pc1_d = alu_r;
      end
      lc3_pkg::S_OFS: begin
        alu_x = pc1_q;
        alu_y = (opc == lc3_pkg::OP_JSR) ? off11 : off9;
        tgt_d = alu_r;
      end
      lc3_pkg::S_RDB: begin
        a_d = rf_eff;
        if (opc inside {lc3_pkg::OP_ST, lc3_pkg::OP_STI, lc3_pkg::OP_STR}) begin
          rf_raddr = dr;
        end else begin
          rf_raddr = sr2;
        end
      end
      lc3_pkg::S_ADDR: begin
        b_d   = rf_eff;
        alu_x = a_q;
        alu_y = off6;
        if ((opc == lc3_pkg::OP_LDR) || (opc == lc3_pkg::OP_STR)) begin
          maddr_d = alu_r;
        end else begin
          maddr_d = tgt_q;
        end
      end
      lc3_pkg::S_M1_RD: mem_re = 1'b1;
      lc3_pkg::S_M1_WT: begin
        m_d     = mem_rdata;
        maddr_d = mem_rdata;
      end
      lc3_pkg::S_M2_RD: mem_re = 1'b1;
      lc3_pkg::S_M2_WT: m_d = mem_rdata;
      lc3_pkg::S_EXEC: begin
        done_d = 1'b1;
        pc_d   = pc1_q;
        alu_x  = a_q;
        alu_y  = ir_q[5] ? imm5 : b_q;
        case (opc)
          lc3_pkg::OP_BR: begin
            if (br_taken) begin
              pc_d = tgt_q;
            end
          end
          lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT: begin
            if (opc == lc3_pkg::OP_AND) begin
              alu_fn = lc3_pkg::ALU_AND;
            end else if (opc == lc3_pkg::OP_NOT) begin
              alu_fn = lc3_pkg::ALU_NOT;
            end
            rw   = 1'b1;
            rn   = dr;
            rv   = alu_r;
            cc_d = lc3_pkg::cc_of(alu_r);
          end
          lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_LDR: begin
            rw   = 1'b1;
            rn   = dr;
            rv   = m_q;
            cc_d = lc3_pkg::cc_of(m_q);
          end
          lc3_pkg::OP_LEA: begin
            rw = 1'b1;
            rn = dr;
            rv = tgt_q;
          end
          lc3_pkg::OP_ST, lc3_pkg::OP_STI, lc3_pkg::OP_STR: begin
            mw     = 1'b1;
            mem_we = 1'b1;
          end
          lc3_pkg::OP_JMP: pc_d = a_q;
          lc3_pkg::OP_JSR: begin
            pc_d = ir_q[11] ? tgt_q : a_q;
            rw   = 1'b1;
            rn   = lc3_pkg::LINK_REG;
            rv   = pc1_q;
          end
          lc3_pkg::OP_HALT: begin
            halt_d = 1'b1;
            pc_d   = pc_q;
          end
          default: pc_d = pc1_q;
        endcase
        if (rw) begin
          rf_we          = 1'b1;
          rf_waddr       = rn;
          rf_wdata       = rv;
          rf_valid_d[rn] = 1'b1;
        end
      end
      default: done_d = 1'b0;
    endcase

    if (done_d) begin
      result_d.next_pc     = pc_d;
      result_d.halted      = halt_d;
      result_d.cond_code   = cc_d;
      result_d.reg_written = rw;
      result_d.reg_number  = rn;
      result_d.reg_value   = rv;
      result_d.mem_written = mw;
      result_d.mem_address = mw ? maddr_q : 16'd0;
      result_d.mem_value   = mw ? b_q : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= lc3_pkg::S_CLEAR;
      clr_q      <= '0;
      pc_q       <= lc3_pkg::PC_RESET;
      cc_q       <= lc3_pkg::CC_ZERO;
      halt_q     <= 1'b0;
      rf_valid_q <= '0;
      done_q     <= 1'b0;
      start_q    <= lc3_pkg::START_INIT;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pc_q       <= pc_d;
      cc_q       <= cc_d;
      halt_q     <= halt_d;
      rf_valid_q <= rf_valid_d;
      done_q     <= done_d;
      if (cfg_we) begin
        start_q <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    ir_q     <= ir_d;
    pc1_q    <= pc1_d;
    tgt_q    <= tgt_d;
    a_q      <= a_d;
    b_q      <= b_d;
    m_q      <= m_d;
    maddr_q  <= maddr_d;
    rsel_q   <= rsel_d;
    quo_q    <= prod[PROD_W-1:32];
    rf_vld_q <= rf_valid_q[rf_raddr];
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  lc3_ram #(
    .WIDTH (16),
    .DEPTH (MEM_WORDS)
  ) u_word_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (phys),
    .rdata_o (mem_rdata)
  );

  lc3_ram #(
    .WIDTH (16),
    .DEPTH (8)
  ) u_reg_file (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (1'b1),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

endmodule

/* rtl/core/lc3_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the word memory and the register file; depends on nothing.
`timescale 1ns / 1ps

module lc3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for lc3_instruction_executor: directed special cases, then random
// LC-3 programs loaded, started and stepped under several sender idling phases.
// Depends on lc3_pkg and the RTL of lc3_instruction_executor.
`timescale 1ns / 1ps

module tb_top;
  import lc3_pkg::*;

  localparam logic [2:0] START_ADDR_OFS = {CFG_START, 2'b00};

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  item_t       item_i  = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        done_o;
  result_t     result_o;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the core state
  logic [15:0] sim_mem [MEM_WORDS_DEF];
  logic [15:0] sim_regs [8];
  logic [15:0] sim_pc;
  logic [1:0]  sim_cc;
  logic        sim_halted;
  logic [15:0] sim_start_addr;

  result_t     expected_results [$];
  int          fails = 0;
  int          idle_pct = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          kind_count [4] = '{0, 0, 0, 0};
  int          halted_steps = 0;
  int          cfg_writes = 0;
  logic [15:0] ops_seen = '0;

  lc3_instruction_executor u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("lc3_instruction_executor verification failed");
    $finish;
  end

  function automatic logic [1:0] flags_for(input logic [15:0] v);
    if (v == 16'd0) return CC_ZERO;
    if (v[15]) return CC_NEG;
    return CC_POS;
  endfunction

  function automatic result_t execute_item(input item_t it);
    result_t     r;
    logic [15:0] ir;
    logic [15:0] pc1;
    logic [15:0] off9;
    logic [15:0] off6;
    logic [15:0] opnd;
    logic [15:0] ea;
    logic [2:0]  dr;
    logic [2:0]  sr1;
    logic        sets_cc;
    r = '0;
    sets_cc = 1'b1;
    case (it.kind)
      KIND_LOAD: begin
        sim_mem[it.load_address] = it.load_data;
      end
      KIND_START: begin
        sim_pc = sim_start_addr;
        for (int i = 0; i < 8; i++) sim_regs[i] = REG_INIT;
        sim_cc = CC_ZERO;
        sim_halted = 1'b0;
      end
      KIND_READ: begin
        r.reg_number = it.reg_select;
        r.reg_value = sim_regs[it.reg_select];
      end
      default: begin
        if (sim_halted) begin
          halted_steps++;
        end else begin
          ir = sim_mem[sim_pc];
          dr = ir[11:9];
          sr1 = ir[8:6];
          off9 = {{7{ir[8]}}, ir[8:0]};
          off6 = {{10{ir[5]}}, ir[5:0]};
          ops_seen[ir[15:12]] = 1'b1;
          if (ir[15:12] == OP_HALT) begin
            sim_halted = 1'b1;
          end else begin
            pc1 = sim_pc + 16'd1;
            sim_pc = pc1;
            case (ir[15:12])
              OP_BR: begin
                if ((sim_cc == CC_NEG && ir[11]) || (sim_cc == CC_ZERO && ir[10]) ||
                    (sim_cc == CC_POS && ir[9])) begin
                  sim_pc = pc1 + off9;
                end
              end
              OP_ADD, OP_AND: begin
                opnd = ir[5] ? {{11{ir[4]}}, ir[4:0]} : sim_regs[ir[2:0]];
                r.reg_value = (ir[15:12] == OP_ADD) ? sim_regs[sr1] + opnd
                                                    : sim_regs[sr1] & opnd;
                r.reg_written = 1'b1;
                r.reg_number = dr;
              end
              OP_NOT: begin
                r.reg_value = ~sim_regs[sr1];
                r.reg_written = 1'b1;
                r.reg_number = dr;
              end
              OP_LD: begin
                ea = pc1 + off9;
                r.reg_value = sim_mem[ea];
                r.reg_written = 1'b1;
                r.reg_number = dr;
              end
              OP_LDI: begin
                ea = pc1 + off9;
                r.reg_value = sim_mem[sim_mem[ea]];
                r.reg_written = 1'b1;
                r.reg_number = dr;
              end
              OP_LDR: begin
                ea = sim_regs[sr1] + off6;
                r.reg_value = sim_mem[ea];
                r.reg_written = 1'b1;
                r.reg_number = dr;
              end
              OP_LEA: begin
                r.reg_value = pc1 + off9;
                r.reg_written = 1'b1;
                r.reg_number = dr;
                sets_cc = 1'b0;
              end
              OP_ST: begin
                r.mem_address = pc1 + off9;
                r.mem_value = sim_regs[dr];
                r.mem_written = 1'b1;
              end
              OP_STI: begin
                ea = pc1 + off9;
                r.mem_address = sim_mem[ea];
                r.mem_value = sim_regs[dr];
                r.mem_written = 1'b1;
              end
              OP_STR: begin
                r.mem_address = sim_regs[sr1] + off6;
                r.mem_value = sim_regs[dr];
                r.mem_written = 1'b1;
              end
              OP_JMP: begin
                sim_pc = sim_regs[sr1];
              end
              OP_JSR: begin
                sim_pc = ir[11] ? pc1 + {{5{ir[10]}}, ir[10:0]} : sim_regs[sr1];
                r.reg_value = pc1;
                r.reg_written = 1'b1;
                r.reg_number = LINK_REG;
                sets_cc = 1'b0;
              end
              default: ;
            endcase
            if (r.reg_written) begin
              sim_regs[r.reg_number] = r.reg_value;
              if (sets_cc) sim_cc = flags_for(r.reg_value);
            end
            if (r.mem_written) sim_mem[r.mem_address] = r.mem_value;
          end
        end
      end
    endcase
    r.next_pc = sim_pc;
    r.halted = sim_halted;
    r.cond_code = sim_cc;
    return r;
  endfunction

  function automatic logic [15:0] random_instruction();
    logic [3:0]  op;
    logic [11:0] body;
    op = 4'($urandom_range(0, 15));
    if (op == OP_HALT && $urandom_range(0, 3) != 0) op = 4'($urandom_range(0, 14));
    body = 12'($urandom);
    // keep offsets short half the time so programs stay in loaded code
    if ($urandom_range(0, 1) == 1) body[8:4] = {5{body[3]}};
    return {op, body};
  endfunction

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fails++;
    end
  endtask

  always @(negedge clk_i) begin
    result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction, next_pc %h", result_o.next_pc);
        fails++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("next_pc", want.next_pc, result_o.next_pc);
        check_field("halted", 16'(want.halted), 16'(result_o.halted));
        check_field("cond_code", 16'(want.cond_code), 16'(result_o.cond_code));
        check_field("reg_written", 16'(want.reg_written), 16'(result_o.reg_written));
        check_field("reg_number", 16'(want.reg_number), 16'(result_o.reg_number));
        check_field("reg_value", want.reg_value, result_o.reg_value);
        check_field("mem_written", 16'(want.mem_written), 16'(result_o.mem_written));
        check_field("mem_address", want.mem_address, result_o.mem_address);
        check_field("mem_value", want.mem_value, result_o.mem_value);
      end
    end
  end

  task automatic send_item(input item_t it);
    item_i <= it;
    start <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    expected_results.push_back(execute_item(it));
    kind_count[it.kind]++;
    items_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic load_word(input logic [15:0] addr, input logic [15:0] data);
    item_t it;
    it.kind = KIND_LOAD;
    it.load_address = addr;
    it.load_data = data;
    it.reg_select = 3'($urandom);
    send_item(it);
  endtask

  task automatic issue(input logic [1:0] kind, input logic [2:0] sel);
    item_t it;
    it.kind = kind;
    it.load_address = 16'($urandom);
    it.load_data = 16'($urandom);
    it.reg_select = sel;
    send_item(it);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_results.size() > 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_results.size() > 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fails++;
      expected_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_start_address(input logic [15:0] addr);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= START_ADDR_OFS;
    pwdata <= {16'h0000, addr};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sim_start_addr = addr;
    cfg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    check_field("start_address readback", addr, prdata[15:0]);
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_state();
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) issue(KIND_READ, 3'(i));
    // cleared memory reads as a branch with no condition bits
    issue(KIND_STEP, 3'd0);
    drain_results();
    write_start_address(16'hFFFF);
  endtask

  task automatic test_special_cases();
    load_word(16'h0000, 16'hFFFF);
    load_word(16'hFFFF, {OP_JSR, 1'b0, 2'b00, LINK_REG, 6'd0});
    load_word(16'h7777, {OP_LEA, 3'd1, 9'h100});
    load_word(16'h7778, {OP_HALT, 12'h025});
    issue(KIND_START, 3'd0);
    repeat (4) issue(KIND_STEP, 3'd0);
    issue(KIND_READ, 3'd7);
    issue(KIND_READ, 3'd1);
    issue(KIND_START, 3'd0);
    issue(KIND_STEP, 3'd0);
    drain_results();
    write_start_address(16'h0000);
    issue(KIND_START, 3'd0);
    issue(KIND_STEP, 3'd0);
    issue(KIND_STEP, 3'd0);
    drain_results();
  endtask

  task automatic run_program();
    logic [15:0] base;
    int          len;
    int          roll;
    drain_results();
    roll = $urandom_range(0, 9);
    base = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : (roll == 2) ? START_INIT
                                                                         : 16'($urandom);
    write_start_address(base);
    repeat ($urandom_range(0, 3)) load_word(base + 16'($urandom_range(0, 63)), 16'($urandom));
    len = $urandom_range(3, 12);
    for (int i = 0; i < len; i++) load_word(base + 16'(i), random_instruction());
    issue(KIND_START, 3'($urandom));
    repeat (len + $urandom_range(0, 6)) begin
      roll = $urandom_range(0, 99);
      if (roll < 14) begin
        issue(KIND_READ, 3'($urandom));
      end else if (roll < 18) begin
        load_word(16'($urandom), 16'($urandom));
      end else if (roll < 20) begin
        issue(KIND_START, 3'($urandom));
      end else begin
        issue(KIND_STEP, 3'($urandom));
      end
    end
  endtask

  task automatic test_random_programs(input int pct, input int count);
    int target;
    idle_pct = pct;
    target = items_sent + count;
    while (items_sent < target) run_program();
    drain_results();
  endtask

  initial begin
    foreach (sim_mem[i]) sim_mem[i] = 16'h0000;
    foreach (sim_regs[i]) sim_regs[i] = REG_INIT;
    sim_pc = PC_RESET;
    sim_cc = CC_ZERO;
    sim_halted = 1'b0;
    sim_start_addr = START_INIT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_special_cases();
    test_random_programs(0, 170);
    test_random_programs(65, 170);
    test_random_programs(7, 170);

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d transactions: %0d loads, %0d starts, %0d steps, %0d register reads",
             items_sent, kind_count[KIND_LOAD], kind_count[KIND_START], kind_count[KIND_STEP],
             kind_count[KIND_READ]);
    $display("Checked %0d results; executed %0d of 16 opcodes, %0d steps while halted",
             results_checked, $countones(ops_seen), halted_steps);
    $display("Wrote the start address %0d times", cfg_writes);
    if (fails == 0) begin
      $display("lc3_instruction_executor verification clean");
    end else begin
      $display("lc3_instruction_executor verification failed");
    end
    $finish;
  end

endmodule
